// ===== hw/rtl/rlpc_pkg.sv =====
// Shared types and constants for the RGB LED PWM command controller.
// No dependencies; imported by rlpc_core and the top level.
`timescale 1ns / 1ps

package rlpc_pkg;

    localparam int DUTY_W  = 7;   // duty, ramp level and PWM phase width
    localparam int VALUE_W = 34;  // delay and reported value width

    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;
    localparam logic [DUTY_W-1:0]  RAMP_TOP    = 7'd100;
    localparam logic [VALUE_W-1:0] DELAY_RESET = 34'd100000;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_F = 8'h46;

    localparam logic [2:0] ST_TICK       = 3'd0;
    localparam logic [2:0] ST_DUTY_SET   = 3'd1;
    localparam logic [2:0] ST_EFFECT_ON  = 3'd2;
    localparam logic [2:0] ST_EFFECT_OFF = 3'd3;
    localparam logic [2:0] ST_DELAY_SET  = 3'd4;
    localparam logic [2:0] ST_BAD_CHAN   = 3'd5;
    localparam logic [2:0] ST_BAD_VALUE  = 3'd6;

    typedef struct packed {
        logic       mode;
        logic [7:0] target_char;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic [7:0] third_char;
    } item_t;

    typedef struct packed {
        logic               red_on;
        logic               green_on;
        logic               blue_on;
        logic [2:0]         status;
        logic [VALUE_W-1:0] reported_value;
    } result_t;

    // 10^e for e in 0..9
    function automatic logic [VALUE_W-1:0] pow10(input logic [3:0] e);
        logic [VALUE_W-1:0] r;
        begin
            unique case (e)
                4'd0:    r = 34'd1;
                4'd1:    r = 34'd10;
                4'd2:    r = 34'd100;
                4'd3:    r = 34'd1000;
                4'd4:    r = 34'd10000;
                4'd5:    r = 34'd100000;
                4'd6:    r = 34'd1000000;
                4'd7:    r = 34'd10000000;
                4'd8:    r = 34'd100000000;
                4'd9:    r = 34'd1000000000;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/rlpc_core.sv =====
// Controller state and the single-pass next-state / result logic.
// Depends on rlpc_pkg.
`timescale 1ns / 1ps

module rlpc_core #(
    parameter int NUM_CHANNELS = 3,
    parameter int PWM_STEPS    = 100,
    parameter int TICK_US      = 100
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  rlpc_pkg::item_t item,
    output rlpc_pkg::result_t res
);
    import rlpc_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CW-1:0]     LAST_CH  = CW'(NUM_CHANNELS - 1);
    localparam logic [DUTY_W-1:0] LAST_PH  = DUTY_W'(PWM_STEPS - 1);
    localparam logic [VALUE_W-1:0] TICK_V  = VALUE_W'(TICK_US);

    typedef struct packed {
        logic [DUTY_W-1:0] level;
        logic              falling;
    } ramp_t;

    function automatic ramp_t advance_ramp(input ramp_t r);
        ramp_t n;
        begin
            n = r;
            if (!r.falling) begin
                if (r.level >= RAMP_TOP) n.falling = 1'b1;
                else                     n.level   = r.level + 1'b1;
            end
            else begin
                if (r.level == '0) n.falling = 1'b0;
                else               n.level   = r.level - 1'b1;
            end
            return n;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= ASCII_ZERO) && (ch <= ASCII_ZERO + 8'd9);
    endfunction

    logic [DUTY_W-1:0]       duty_reg [NUM_CHANNELS];
    logic [DUTY_W-1:0]       duty_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] en_reg, en_next;
    logic [NUM_CHANNELS-1:0] led_reg, led_next;
    logic [VALUE_W-1:0]      delay_reg, delay_next;
    logic [VALUE_W-1:0]      wait_reg, wait_next;
    logic [DUTY_W-1:0]       phase_reg, phase_next;
    ramp_t                   ramp_reg, ramp_next;
    logic [CW-1:0]           rc_reg, rc_next;

    // effect search
    logic          found_hi;
    logic [CW-1:0] hi_idx, lo_idx, sel;
    ramp_t         ramp_pre;

    // command decode
    logic                    all_ch, chan_ok;
    int unsigned             tgt;
    logic [NUM_CHANNELS-1:0] mask;
    logic [3:0]              dig_b, dig_d;
    logic [DUTY_W:0]         duty_raw;
    logic [DUTY_W-1:0]       duty_val;
    logic [VALUE_W-1:0]      delay_val;
    logic [2:0]              status;
    logic [VALUE_W-1:0]      value;
    logic [2:0]              led3;

    always_comb
    begin
        duty_next  = duty_reg;
        en_next    = en_reg;
        led_next   = led_reg;
        delay_next = delay_reg;
        wait_next  = wait_reg;
        phase_next = phase_reg;
        ramp_next  = ramp_reg;
        rc_next    = rc_reg;
        status     = ST_TICK;
        value      = '0;

        // next enabled channel at or past the ramp position, else first enabled
        found_hi = 1'b0;
        hi_idx   = '0;
        lo_idx   = '0;
        for (int c = NUM_CHANNELS - 1; c >= 0; c--)
        begin
            if (en_reg[c]) begin
                lo_idx = CW'(c);
                if (CW'(c) >= rc_reg) begin
                    hi_idx   = CW'(c);
                    found_hi = 1'b1;
                end
            end
        end
        ramp_pre = found_hi ? ramp_reg : advance_ramp(ramp_reg);
        sel      = found_hi ? hi_idx : lo_idx;

        // target decode
        all_ch = 1'b0;
        tgt    = 0;
        chan_ok = 1'b1;
        unique case (item.target_char)
            CH_R:    tgt = 0;
            CH_G:    tgt = 1;
            CH_B:    tgt = 2;
            CH_A:    all_ch = 1'b1;
            default: chan_ok = 1'b0;
        endcase
        if (!all_ch && tgt >= NUM_CHANNELS) chan_ok = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            mask[i] = all_ch || (tgt == i);
        end

        dig_b     = 4'(item.second_char - ASCII_ZERO);
        dig_d     = 4'(item.third_char - ASCII_ZERO);
        delay_val = VALUE_W'({30'b0, dig_b} * pow10(dig_d));
        duty_raw  = ((item.first_char == ASCII_ONE) ? 8'd100 : 8'd0)
                    + ({4'b0, dig_b} * 8'd10) + {4'b0, dig_d};
        duty_val  = (duty_raw > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_raw[DUTY_W-1:0];

        if (fire) begin
            if (!item.mode) begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    led_next[c] = phase_reg < duty_reg[c];
                end
                phase_next = (phase_reg == LAST_PH) ? '0 : phase_reg + 1'b1;

                if (wait_reg > TICK_V) begin
                    wait_next = wait_reg - TICK_V;
                end
                else if (en_reg == '0) begin
                    wait_next = '0;
                end
                else begin
                    duty_next[sel] = ramp_pre.level;
                    if (sel == LAST_CH) begin
                        rc_next   = '0;
                        ramp_next = advance_ramp(ramp_pre);
                    end
                    else begin
                        rc_next   = sel + 1'b1;
                        ramp_next = ramp_pre;
                    end
                    wait_next = delay_reg;
                end
            end
            else if (!chan_ok) begin
                status = ST_BAD_CHAN;
            end
            else if (item.first_char == CH_E) begin
                if (item.second_char == CH_N || item.second_char == CH_F) begin
                    for (int c = 0; c < NUM_CHANNELS; c++)
                    begin
                        if (mask[c]) en_next[c] = (item.second_char == CH_N);
                    end
                    status = (item.second_char == CH_N) ? ST_EFFECT_ON : ST_EFFECT_OFF;
                end
                else if (is_digit(item.second_char) && is_digit(item.third_char)) begin
                    delay_next = delay_val;
                    value      = delay_val;
                    status     = ST_DELAY_SET;
                end
                else begin
                    status = ST_BAD_VALUE;
                end
            end
            else if ((item.first_char == ASCII_ZERO || item.first_char == ASCII_ONE)
                     && is_digit(item.second_char) && is_digit(item.third_char)) begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (mask[c]) duty_next[c] = duty_val;
                end
                value  = VALUE_W'(duty_val);
                status = ST_DUTY_SET;
            end
            else begin
                status = ST_BAD_VALUE;
            end
        end

        led3 = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            led3[c] = led_next[c];
        end
        res.red_on         = led3[0];
        res.green_on       = led3[1];
        res.blue_on        = led3[2];
        res.status         = status;
        res.reported_value = value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                duty_reg[c] <= '0;
            end
            en_reg    <= '0;
            led_reg   <= '0;
            delay_reg <= DELAY_RESET;
            wait_reg  <= '0;
            phase_reg <= '0;
            ramp_reg  <= '0;
            rc_reg    <= '0;
        end
        else begin
            duty_reg  <= duty_next;
            en_reg    <= en_next;
            led_reg   <= led_next;
            delay_reg <= delay_next;
            wait_reg  <= wait_next;
            phase_reg <= phase_next;
            ramp_reg  <= ramp_next;
            rc_reg    <= rc_next;
        end
    end

endmodule

// ===== hw/rtl/rgb_led_pwm_command_controller.sv =====
// Top level of the RGB LED PWM command controller: input and result registers.
// Depends on rlpc_pkg and rlpc_core.
`timescale 1ns / 1ps

// Usage
//   Input channel: one beat is a timer tick (mode = 0) or a four-character
//   ASCII command (mode = 1: channel letter, then duty digits, or E with
//   N / F / delay digit and exponent). A beat is taken on a clock edge with
//   in_valid high and in_stall low.
//   Output channel: exactly one result beat per input beat, in order: the
//   three LED drive levels after the beat, a status code and the duty or
//   delay just set (zero otherwise). Taken when out_valid high, out_stall low.
//   Pipeline: from the accepting edge, the input register, then the result
//   register. Throughput: one beat per cycle while out_stall is low; the
//   state update is a single pass of shallow logic, the delay being a 4-bit
//   by 34-bit product against a power-of-ten table.
//   Stall: the result register holds while out_stall is high; the input
//   register still takes one more beat, after which in_stall follows
//   out_stall until the result is taken.
//   Reset (rst_n low, asynchronous): both registers empty, duties and
//   enables cleared, effect delay 100000 us, PWM phase, ramp and wait zero.
module rgb_led_pwm_command_controller #(
    parameter int NUM_CHANNELS = 3,
    parameter int PWM_STEPS    = 100,
    parameter int TICK_US      = 100
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  target_char,
    input  logic [7:0]  first_char,
    input  logic [7:0]  second_char,
    input  logic [7:0]  third_char,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        red_on,
    output logic        green_on,
    output logic        blue_on,
    output logic [2:0]  status,
    output logic [33:0] reported_value
);
    import rlpc_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t res_reg, res_next;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    accept;

    // Item moves into the result register when that register is free or draining.
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    rlpc_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PWM_STEPS    (PWM_STEPS),
        .TICK_US      (TICK_US)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .res   (res_next)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)       item_valid_next = 1'b1;
        else if (advance) item_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)         res_valid_next = 1'b1;
        else if (!out_stall) res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept) begin
            item_reg.mode        <= mode;
            item_reg.target_char <= target_char;
            item_reg.first_char  <= first_char;
            item_reg.second_char <= second_char;
            item_reg.third_char  <= third_char;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign red_on         = res_reg.red_on;
    assign green_on       = res_reg.green_on;
    assign blue_on        = res_reg.blue_on;
    assign status         = res_reg.status;
    assign reported_value = res_reg.reported_value;

endmodule
